// ===== design/jac_pkg.sv =====
// ============================================================================
// Jacobi eigensolver package
// Shared widths, fixed-point constants, beat types and helper functions for
// the 3x3 symmetric Jacobi eigensolver and its CORDIC unit.
// ============================================================================
package jac_pkg;

    // Matrix entries: signed Q16.16 held in 34 bits; eigenvectors Q2.30 in 34 bits
    localparam int A_W    = 34;
    // CORDIC datapath: x/y grow past the input range, angles reach about 1.5*pi
    localparam int X_W    = 40;
    localparam int Z_W    = 36;
    // Rotation coefficients c and s, Q2.30, within +-1.0
    localparam int CS_W   = 32;
    // Full product of an entry and a coefficient
    localparam int P_W    = A_W + CS_W;
    // Accumulator for rounded products before saturation
    localparam int ACC_W  = 40;
    // Arctangent table addressing
    localparam int ATAN_N  = 32;
    localparam int ATAN_IW = 5;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic signed [X_W-1:0]   ONE_Q30_X  = 40'sd1073741824;
    localparam logic signed [CS_W-1:0]  ONE_Q30_CS = 32'sd1073741824;
    localparam logic signed [A_W-1:0]   ONE_Q30_A  = 34'sd1073741824;
    localparam logic signed [X_W-1:0]   INV_GAIN   = 40'sd652032874;
    localparam logic signed [Z_W-1:0]   PI_Q30     = 36'sd3373259426;
    localparam logic signed [P_W-1:0]   HALF_LSB   = 66'sd536870912;
    localparam logic signed [ACC_W-1:0] WIDE_LIM   = 40'sd8589934591;
    localparam logic signed [A_W-1:0]   S32_MAX    = 34'sd2147483647;
    localparam logic signed [A_W-1:0]   S32_MIN    = -34'sd2147483648;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_ITER_LIMIT = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [5:0]  ITER_LIMIT_RST = 6'd12;
    localparam logic [30:0] THRESHOLD_RST  = 31'd1;

    typedef struct packed {
        logic signed [31:0] m_00;
        logic signed [31:0] m_01;
        logic signed [31:0] m_02;
        logic signed [31:0] m_11;
        logic signed [31:0] m_12;
        logic signed [31:0] m_22;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] eigval_0;
        logic signed [31:0] eigval_1;
        logic signed [31:0] eigval_2;
        logic signed [31:0] vec0_r0;
        logic signed [31:0] vec0_r1;
        logic signed [31:0] vec0_r2;
        logic signed [31:0] vec1_r0;
        logic signed [31:0] vec1_r1;
        logic signed [31:0] vec1_r2;
        logic signed [31:0] vec2_r0;
        logic signed [31:0] vec2_r1;
        logic signed [31:0] vec2_r2;
    } t_out_item;

    // Request to the CORDIC unit: start pulse and the (x, y) vector
    typedef struct packed {
        logic                  start;
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
    } t_cordic_req;

    // Response from the CORDIC unit: done pulse with cosine and sine
    typedef struct packed {
        logic                   done;
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
    } t_cordic_rsp;

    // Arctangent of 2^-i in Q2.30
    function automatic logic [29:0] atan_lut(input logic [ATAN_IW-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            5'd24:   v = 30'h0000003F;
            5'd25:   v = 30'h0000001F;
            5'd26:   v = 30'h0000000F;
            5'd27:   v = 30'h00000008;
            5'd28:   v = 30'h00000004;
            5'd29:   v = 30'h00000002;
            5'd30:   v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    // Saturate an accumulated sum to the stored entry range +-(2^33-1)
    function automatic logic signed [A_W-1:0] sat_wide(input logic signed [ACC_W-1:0] v);
        logic signed [A_W-1:0] r;
        if (v > WIDE_LIM) begin
            r = A_W'(WIDE_LIM);
        end else if (v < -WIDE_LIM) begin
            r = A_W'(-WIDE_LIM);
        end else begin
            r = A_W'(v);
        end
        return r;
    endfunction

    // Saturate a stored entry to the signed 32-bit output range
    function automatic logic signed [31:0] sat32(input logic signed [A_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/symmetric_3x3_jacobi_eigensolver.sv =====
// ============================================================================
// Symmetric 3x3 Jacobi eigensolver
// Classical Jacobi rotations on a symmetric Q16.16 matrix; returns the
// unsorted diagonal as eigenvalues and the eigenvector columns in Q2.30.
// ============================================================================
// Usage: pulse start with the six matrix entries while busy is low. Each
// rotation picks the pivot in S_SCAN, loads the CORDIC in S_PREP, runs a
// vectoring and a rotation pass of CORDIC_STEPS micro-rotations each, then
// does the A and V updates, which run every product through one shared
// 34x32 multiplier. When the rotation input 2*Aqp is zero the CORDIC passes
// are skipped. An item stops after at most the iteration limit of rotations,
// twelve at reset, or once the largest off-diagonal entry is below the
// threshold. The result is shown for exactly one cycle with o_result_valid
// and is not held: the receiver must take it then. busy falls in that same
// cycle.
// ============================================================================
module symmetric_3x3_jacobi_eigensolver #(
    parameter int CORDIC_STEPS = jac_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  jac_pkg::t_in_item i_item,
    output logic              o_result_valid,
    output jac_pkg::t_out_item o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam int AW = jac_pkg::A_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_PREP = 5'b00100,
        S_CORD = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

    // Pivot pairs in scan order
    localparam logic [1:0] PAIR_01 = 2'd0;
    localparam logic [1:0] PAIR_02 = 2'd1;
    localparam logic [1:0] PAIR_12 = 2'd2;

    // Update phases: columns of A, rows of A, columns of V
    localparam logic [1:0] PH_ACOL = 2'd0;
    localparam logic [1:0] PH_AROW = 2'd1;
    localparam logic [1:0] PH_VCOL = 2'd2;

    t_state r_state, n_state;

    logic [5:0]  r_iter_limit;
    logic [30:0] r_threshold;
    logic [5:0]  r_iter;
    logic [1:0]  r_pair;
    logic [1:0]  r_phase;
    logic [1:0]  r_row;
    logic [2:0]  r_k;

    logic signed [AW-1:0] r_a [9];
    logic signed [AW-1:0] r_v [9];
    logic signed [jac_pkg::CS_W-1:0] r_c;
    logic signed [jac_pkg::CS_W-1:0] r_s;
    logic signed [jac_pkg::P_W-1:0]  r_prod;
    logic signed [jac_pkg::ACC_W-1:0] r_acc_p;
    logic signed [jac_pkg::ACC_W-1:0] r_acc_q;
    logic                r_out_valid;
    jac_pkg::t_out_item  r_out;

    jac_pkg::t_cordic_req cordic_req;
    jac_pkg::t_cordic_rsp cordic_rsp;

    function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
        return {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
    endfunction

    function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] v);
        return (v < 0) ? AW'(-v) : AW'(v);
    endfunction

    // Pivot search over the three sub-diagonal entries
    logic [AW-1:0] mag01, mag02, mag12, best;
    logic [1:0]    best_pair;
    logic          stop;

    always_comb begin
        mag01     = mag(r_a[3]);
        mag02     = mag(r_a[6]);
        mag12     = mag(r_a[7]);
        best      = mag01;
        best_pair = PAIR_01;
        if (mag02 > best) begin
            best      = mag02;
            best_pair = PAIR_02;
        end
        if (mag12 > best) begin
            best      = mag12;
            best_pair = PAIR_12;
        end
        stop = (r_iter >= r_iter_limit) || (best < AW'(r_threshold));
    end

    // Decode the pivot pair
    logic [1:0] piv_p, piv_q;

    always_comb begin
        unique case (r_pair)
            PAIR_01: begin
                piv_p = 2'd0;
                piv_q = 2'd1;
            end
            PAIR_02: begin
                piv_p = 2'd0;
                piv_q = 2'd2;
            end
            default: begin
                piv_p = 2'd1;
                piv_q = 2'd2;
            end
        endcase
    end

    // CORDIC vector: (Aqq - App, 2*Aqp)
    always_comb begin
        cordic_req.start = (r_state == S_PREP);
        unique case (r_pair)
            PAIR_01: begin
                cordic_req.x = jac_pkg::X_W'(r_a[4]) - jac_pkg::X_W'(r_a[0]);
                cordic_req.y = jac_pkg::X_W'(r_a[3]) <<< 1;
            end
            PAIR_02: begin
                cordic_req.x = jac_pkg::X_W'(r_a[8]) - jac_pkg::X_W'(r_a[0]);
                cordic_req.y = jac_pkg::X_W'(r_a[6]) <<< 1;
            end
            default: begin
                cordic_req.x = jac_pkg::X_W'(r_a[8]) - jac_pkg::X_W'(r_a[4]);
                cordic_req.y = jac_pkg::X_W'(r_a[7]) <<< 1;
            end
        endcase
    end

    jac_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cordic_req),
        .o_rsp   (cordic_rsp)
    );

    // Update operand selection: p side for the first two products, q side after
    logic [3:0] idx_p, idx_q, idx_rd;
    logic signed [AW-1:0] opnd;
    logic signed [jac_pkg::CS_W-1:0] coef;
    logic signed [jac_pkg::P_W-1:0]  prod_rnd;
    logic signed [jac_pkg::ACC_W-1:0] rnd;
    logic signed [AW-1:0] new_p, new_q;

    always_comb begin
        if (r_phase == PH_AROW) begin
            idx_p = idx3(piv_p, r_row);
            idx_q = idx3(piv_q, r_row);
        end else begin
            idx_p = idx3(r_row, piv_p);
            idx_q = idx3(r_row, piv_q);
        end
        idx_rd  = (r_k < 3'd2) ? idx_p : idx_q;
        opnd    = (r_phase == PH_VCOL) ? r_v[idx_rd] : r_a[idx_rd];
        coef    = (r_k == 3'd0 || r_k == 3'd3) ? r_c : r_s;
        // rounded Q30 product of the previous cycle
        prod_rnd = r_prod + jac_pkg::HALF_LSB;
        rnd      = jac_pkg::ACC_W'(prod_rnd >>> 30);
        new_p    = jac_pkg::sat_wide(r_acc_p);
        new_q    = jac_pkg::sat_wide(r_acc_q + rnd);
    end

    // Main sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_state = stop ? S_IDLE : S_PREP;
            end
            S_PREP: begin
                n_state = S_CORD;
            end
            S_CORD: begin
                if (cordic_rsp.done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_k == 3'd4 && r_row == 2'd2 && r_phase == PH_VCOL) begin
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_iter_limit <= jac_pkg::ITER_LIMIT_RST;
            r_threshold  <= jac_pkg::THRESHOLD_RST;
            r_iter       <= '0;
            r_pair       <= PAIR_01;
            r_phase      <= PH_ACOL;
            r_row        <= '0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_SCAN) && stop;
            // take configuration beats
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    jac_pkg::CFG_ITER_LIMIT: r_iter_limit <= i_cfg_data[5:0];
                    jac_pkg::CFG_THRESHOLD:  r_threshold  <= i_cfg_data[30:0];
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    r_iter <= '0;
                end
                S_SCAN: begin
                    r_pair  <= best_pair;
                    r_phase <= PH_ACOL;
                    r_row   <= '0;
                    r_k     <= '0;
                end
                S_UPD: begin
                    // advance product step, then row, then phase
                    if (r_k == 3'd4) begin
                        r_k <= '0;
                        if (r_row == 2'd2) begin
                            r_row <= '0;
                            if (r_phase == PH_VCOL) begin
                                r_phase <= PH_ACOL;
                                r_iter  <= r_iter + 1'b1;
                            end else begin
                                r_phase <= r_phase + 1'b1;
                            end
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Matrix, eigenvector and datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_a[0] <= AW'(i_item.m_00);
            r_a[1] <= AW'(i_item.m_01);
            r_a[2] <= AW'(i_item.m_02);
            r_a[3] <= AW'(i_item.m_01);
            r_a[4] <= AW'(i_item.m_11);
            r_a[5] <= AW'(i_item.m_12);
            r_a[6] <= AW'(i_item.m_02);
            r_a[7] <= AW'(i_item.m_12);
            r_a[8] <= AW'(i_item.m_22);
            for (int i = 0; i < 9; i++) begin
                r_v[i] <= (i % 4 == 0) ? jac_pkg::ONE_Q30_A : '0;
            end
        end
        if (r_state == S_CORD && cordic_rsp.done) begin
            r_c <= cordic_rsp.c;
            r_s <= cordic_rsp.s;
        end
        if (r_state == S_UPD) begin
            if (r_k != 3'd4) begin
                r_prod <= jac_pkg::P_W'(opnd) * jac_pkg::P_W'(coef);
            end
            case (r_k)
                3'd1: r_acc_p <= rnd;
                3'd2: r_acc_q <= rnd;
                3'd3: r_acc_p <= r_acc_p - rnd;
                3'd4: begin
                    if (r_phase == PH_VCOL) begin
                        r_v[idx_p] <= new_p;
                        r_v[idx_q] <= new_q;
                    end else begin
                        r_a[idx_p] <= new_p;
                        r_a[idx_q] <= new_q;
                    end
                end
                default: begin
                end
            endcase
        end
        // capture the finished item
        if (r_state == S_SCAN && stop) begin
            r_out.eigval_0 <= jac_pkg::sat32(r_a[0]);
            r_out.eigval_1 <= jac_pkg::sat32(r_a[4]);
            r_out.eigval_2 <= jac_pkg::sat32(r_a[8]);
            r_out.vec0_r0  <= jac_pkg::sat32(r_v[0]);
            r_out.vec0_r1  <= jac_pkg::sat32(r_v[3]);
            r_out.vec0_r2  <= jac_pkg::sat32(r_v[6]);
            r_out.vec1_r0  <= jac_pkg::sat32(r_v[1]);
            r_out.vec1_r1  <= jac_pkg::sat32(r_v[4]);
            r_out.vec1_r2  <= jac_pkg::sat32(r_v[7]);
            r_out.vec2_r0  <= jac_pkg::sat32(r_v[2]);
            r_out.vec2_r1  <= jac_pkg::sat32(r_v[5]);
            r_out.vec2_r2  <= jac_pkg::sat32(r_v[8]);
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;
    assign o_cfg_ready    = 1'b1;

endmodule

// ===== design/jac_cordic.sv =====
// ============================================================================
// Jacobi CORDIC unit
// Vectoring pass for the double angle atan2(y, x), halving, then a rotation
// pass giving cosine and sine in Q2.30. One micro-rotation per cycle on a
// single shift/add datapath shared by both passes; a zero y skips both passes.
// ============================================================================
module jac_cordic #(
    parameter int CORDIC_STEPS = jac_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  jac_pkg::t_cordic_req i_req,
    output jac_pkg::t_cordic_rsp o_rsp
);

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CW-1:0] STEP_LAST = CW'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_VEC  = 4'b0010,
        C_ROT  = 4'b0100,
        C_DONE = 4'b1000
    } t_cstate;

    t_cstate r_state, n_state;

    logic signed [jac_pkg::X_W-1:0]  r_x, n_x;
    logic signed [jac_pkg::X_W-1:0]  r_y, n_y;
    logic signed [jac_pkg::Z_W-1:0]  r_z, n_z;
    logic        [CW-1:0]            r_step, n_step;
    logic signed [jac_pkg::CS_W-1:0] r_c, n_c;
    logic signed [jac_pkg::CS_W-1:0] r_s, n_s;

    logic signed [jac_pkg::X_W-1:0] sh_x;
    logic signed [jac_pkg::X_W-1:0] sh_y;
    logic signed [jac_pkg::Z_W-1:0] ang;
    logic                           dir_pos;
    logic signed [jac_pkg::X_W-1:0] st_x;
    logic signed [jac_pkg::X_W-1:0] st_y;
    logic signed [jac_pkg::Z_W-1:0] st_z;

    // Shared micro-rotation: shifts, table lookup and three adders
    always_comb begin
        sh_x    = r_x >>> r_step;
        sh_y    = r_y >>> r_step;
        ang     = jac_pkg::Z_W'(jac_pkg::atan_lut(jac_pkg::ATAN_IW'(r_step)));
        dir_pos = (r_state == C_VEC) ? (r_y > 0) : (r_z < 0);
        if (dir_pos) begin
            st_x = r_x + sh_y;
            st_y = r_y - sh_x;
            st_z = r_z + ang;
        end else begin
            st_x = r_x - sh_y;
            st_y = r_y + sh_x;
            st_z = r_z - ang;
        end
    end

    // Sequence the vectoring and rotation passes
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_step  = r_step;
        n_c     = r_c;
        n_s     = r_s;
        unique case (r_state)
            C_IDLE: begin
                if (i_req.start) begin
                    n_step = '0;
                    if (i_req.y == 0) begin
                        // zero rotation input: bypass the iterations
                        n_c     = (i_req.x >= 0) ? jac_pkg::ONE_Q30_CS : '0;
                        n_s     = (i_req.x >= 0) ? '0 : jac_pkg::ONE_Q30_CS;
                        n_state = C_DONE;
                    end else if (i_req.x < 0) begin
                        // pre-rotate by pi into the right half plane
                        n_x     = -i_req.x;
                        n_y     = -i_req.y;
                        n_z     = (i_req.y > 0) ? jac_pkg::PI_Q30 : -jac_pkg::PI_Q30;
                        n_state = C_VEC;
                    end else begin
                        n_x     = i_req.x;
                        n_y     = i_req.y;
                        n_z     = '0;
                        n_state = C_VEC;
                    end
                end
            end
            C_VEC: begin
                if (r_step == STEP_LAST) begin
                    // halve the angle and seed the rotation pass
                    n_z     = st_z >>> 1;
                    n_x     = jac_pkg::INV_GAIN;
                    n_y     = '0;
                    n_step  = '0;
                    n_state = C_ROT;
                end else begin
                    n_x    = st_x;
                    n_y    = st_y;
                    n_z    = st_z;
                    n_step = r_step + 1'b1;
                end
            end
            C_ROT: begin
                n_x = st_x;
                n_y = st_y;
                n_z = st_z;
                if (r_step == STEP_LAST) begin
                    if (st_x > jac_pkg::ONE_Q30_X) begin
                        n_c = jac_pkg::ONE_Q30_CS;
                    end else if (st_x < -jac_pkg::ONE_Q30_X) begin
                        n_c = -jac_pkg::ONE_Q30_CS;
                    end else begin
                        n_c = jac_pkg::CS_W'(st_x);
                    end
                    if (st_y > jac_pkg::ONE_Q30_X) begin
                        n_s = jac_pkg::ONE_Q30_CS;
                    end else if (st_y < -jac_pkg::ONE_Q30_X) begin
                        n_s = -jac_pkg::ONE_Q30_CS;
                    end else begin
                        n_s = jac_pkg::CS_W'(st_y);
                    end
                    n_state = C_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            C_DONE: begin
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_c <= n_c;
        r_s <= n_s;
    end

    assign o_rsp.done = (r_state == C_DONE);
    assign o_rsp.c    = r_c;
    assign o_rsp.s    = r_s;

endmodule
